### rtl/core/flptw_pkg.sv
// Shared types, codes and helpers for the four-level page table walker.
// No dependencies; every other file of the walker imports this package.
`default_nettype none

package flptw_pkg;

	localparam int unsigned PHYS_ADDR_BITS_DEF = 52;
	localparam int unsigned ADDR_W  = 52;
	localparam int unsigned VIRT_W  = 48;
	localparam int unsigned FRAME_W = 40;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned LEVEL_W = 2;
	localparam int unsigned IDX_W   = 9;
	localparam int unsigned OFFS_W  = 12;

	localparam int unsigned OFIFO_DEPTH = 4;
	localparam int unsigned OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
	localparam int unsigned OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

	localparam logic [LEVEL_W-1:0] LEAF_LEVEL = 2'd3;

	typedef enum logic [1:0] {
		REQ_TRANSLATE = 2'd0,
		REQ_UNMAP     = 2'd1,
		REQ_RESPONSE  = 2'd2,
		REQ_RESERVED  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		KIND_READ       = 2'd0,
		KIND_WRITE_ZERO = 2'd1,
		KIND_DONE       = 2'd2,
		KIND_UNUSED     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_MAPPED = 2'd1,
		ST_MISALIGNED = 2'd2,
		ST_BUSY       = 2'd3
	} status_t;

	// Walk context carried from one memory response to the next.
	typedef struct packed {
		logic                  active;
		logic                  unmap;
		logic [LEVEL_W-1:0]    level;
		logic [VIRT_W-1:0]     virt;
		logic [FRAME_W-1:0]    frame;
	} walk_state_t;

	// One result transaction as it sits in the output queue.
	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] mem_addr;
		logic [ADDR_W-1:0] phys_addr;
		status_t           status;
		logic              last;
	} result_t;

	// Table index of a virtual address at a given level (0 is the top level).
	function automatic logic [IDX_W-1:0] level_index(input logic [LEVEL_W-1:0] level,
			input logic [VIRT_W-1:0] va);
		logic [IDX_W-1:0] idx;
		case (level)
			2'd0:    idx = va[47:39];
			2'd1:    idx = va[38:30];
			2'd2:    idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

### rtl/core/flptw_step.sv
// Combinational walk step: one request or response against the walk context.
// Depends on flptw_pkg for the context, result types and codes.
`default_nettype none

module flptw_step #(
	parameter int unsigned PHYS_ADDR_BITS = flptw_pkg::PHYS_ADDR_BITS_DEF
) (
	input  flptw_pkg::req_type_t                 req,
	input  logic [flptw_pkg::VIRT_W-1:0]         virt_addr,
	input  logic [flptw_pkg::DATA_W-1:0]         read_data,
	input  logic [flptw_pkg::FRAME_W-1:0]        root_frame,
	input  flptw_pkg::walk_state_t               cur,
	output flptw_pkg::walk_state_t               nxt,
	output logic [1:0]                           n_res,
	output flptw_pkg::result_t                   res0,
	output flptw_pkg::result_t                   res1
);
	import flptw_pkg::*;

	localparam logic [ADDR_W-1:0] AllMask  = {ADDR_W{1'b1}} >> (ADDR_W - PHYS_ADDR_BITS);
	localparam logic [ADDR_W-1:0] AddrMask = AllMask & ~{{(ADDR_W-OFFS_W){1'b0}},
		{OFFS_W{1'b1}}};

	function automatic logic [ADDR_W-1:0] entry_addr(input logic [FRAME_W-1:0] frame,
			input logic [LEVEL_W-1:0] level, input logic [VIRT_W-1:0] va);
		return ({frame, {OFFS_W{1'b0}}} |
			{{(ADDR_W-IDX_W-3){1'b0}}, level_index(level, va), 3'b000}) & AllMask;
	endfunction

	logic [ADDR_W-1:0]  entry_masked;
	logic [LEVEL_W-1:0] level_inc;

	assign entry_masked = read_data[ADDR_W-1:0] & AddrMask;
	assign level_inc    = cur.level + 2'd1;

	always_comb begin
		nxt   = cur;
		n_res = 2'd0;
		res0  = '0;
		res1  = '0;
		case (req)
			REQ_TRANSLATE, REQ_UNMAP: begin
				n_res     = 2'd1;
				res0.last = 1'b1;
				if (cur.active) begin
					res0.kind   = KIND_DONE;
					res0.status = ST_BUSY;
				end else if (req == REQ_UNMAP && virt_addr[OFFS_W-1:0] != '0) begin
					res0.kind   = KIND_DONE;
					res0.status = ST_MISALIGNED;
				end else begin
					nxt.active    = 1'b1;
					nxt.unmap     = (req == REQ_UNMAP);
					nxt.level     = '0;
					nxt.virt      = virt_addr;
					nxt.frame     = root_frame;
					res0.kind     = KIND_READ;
					res0.mem_addr = entry_addr(root_frame, '0, virt_addr);
				end
			end
			REQ_RESPONSE: begin
				if (cur.active) begin
					n_res     = 2'd1;
					res0.last = 1'b1;
					if (!read_data[0]) begin
						nxt.active  = 1'b0;
						res0.kind   = KIND_DONE;
						res0.status = cur.unmap ? ST_OK : ST_NOT_MAPPED;
					end else if (cur.level == LEAF_LEVEL) begin
						nxt.active     = 1'b0;
						res0.kind      = KIND_DONE;
						res0.phys_addr = entry_masked |
							{{(ADDR_W-OFFS_W){1'b0}}, cur.virt[OFFS_W-1:0]};
					end else begin
						nxt.frame = entry_masked[ADDR_W-1:OFFS_W];
						nxt.level = level_inc;
						if (cur.unmap && level_inc == LEAF_LEVEL) begin
							// Leaf entry is cleared without being read.
							nxt.active    = 1'b0;
							n_res         = 2'd2;
							res0.kind     = KIND_WRITE_ZERO;
							res0.mem_addr = entry_addr(entry_masked[ADDR_W-1:OFFS_W],
								LEAF_LEVEL, cur.virt);
							res0.last     = 1'b0;
							res1.kind     = KIND_DONE;
							res1.status   = ST_OK;
							res1.last     = 1'b1;
						end else begin
							res0.kind     = KIND_READ;
							res0.mem_addr = entry_addr(entry_masked[ADDR_W-1:OFFS_W],
								level_inc, cur.virt);
						end
					end
				end
			end
			default: begin
				n_res = 2'd0;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/flptw_ofifo.sv
// Small output queue taking up to two results per cycle and giving one while the reader is ready.
// Depends on flptw_pkg for the result type and queue sizing.
`default_nettype none

module flptw_ofifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           n_push,
	input  flptw_pkg::result_t   push0,
	input  flptw_pkg::result_t   push1,
	output logic                 room_for_two,
	output logic                 out_valid,
	input  logic                 out_ready,
	output flptw_pkg::result_t   out_res
);
	import flptw_pkg::*;

	result_t                  entry_q [OFIFO_DEPTH];
	logic [OFIFO_PTR_W-1:0]   wr_q;
	logic [OFIFO_PTR_W-1:0]   rd_q;
	logic [OFIFO_CNT_W-1:0]   count_q;
	logic                     pop;
	logic [OFIFO_PTR_W-1:0]   wr_next1;

	assign out_valid    = (count_q != '0);
	assign out_res      = entry_q[rd_q];
	assign pop          = out_valid && out_ready;
	assign room_for_two = (count_q <= OFIFO_CNT_W'(OFIFO_DEPTH - 2));
	assign wr_next1     = wr_q + OFIFO_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			entry_q[wr_q] <= push0;
		end
		if (n_push == 2'd2) begin
			entry_q[wr_next1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + OFIFO_PTR_W'(n_push);
			rd_q    <= rd_q + OFIFO_PTR_W'(pop);
			count_q <= count_q + OFIFO_CNT_W'(n_push) - OFIFO_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

### rtl/core/four_level_page_table_walker_unit.sv
// Four-level page table walker: input register, walk step and output queue.
// Depends on flptw_pkg, flptw_step and flptw_ofifo.
//
// The walker takes translate and unmap requests and the memory's read responses on one
// input stream and emits entry read requests, write-zero commands and completion
// transactions on one output stream. An input transaction is captured in a single input
// register; it is checked against the walk context by short combinational logic, and
// when consumed its one or two results enter a four-deep output queue, from which they
// are offered. A new transaction can be accepted every cycle, so the sustained rate is
// one input per clock; the limit is the output queue, which drains one result per cycle
// while the reader is ready and needs room for two results before the input register
// may advance (an unmap that reaches the leaf yields two). Requests that arrive while a
// walk is in progress complete at once with busy status and leave the walk untouched;
// responses that arrive with no walk in progress, and the reserved request code, are
// dropped without result. The root table frame may be written only while the walker is
// idle with no results outstanding; the configuration channel is always ready.
`default_nettype none

module four_level_page_table_walker_unit #(
	parameter int unsigned PHYS_ADDR_BITS = flptw_pkg::PHYS_ADDR_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	// Configuration write channel: root table frame, physical address bits 51 to 12.
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [39:0]   cfg_data,
	// Input stream.
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [111:0]  s_tdata,   // [47:0] virt_addr, [111:48] read_data
	input  logic [1:0]    s_tuser,   // [1:0] req_type
	// Output stream.
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [111:0]  m_tdata,   // [51:0] mem_addr, [103:52] phys_addr,
	                                 // [105:104] status, [111:106] zero
	output logic [1:0]    m_tuser,   // [1:0] kind
	output logic          m_tlast    // last result of an input transaction
);
	import flptw_pkg::*;

	logic [FRAME_W-1:0] root_frame_q;

	logic               valid_s1;
	req_type_t          req_s1;
	logic [VIRT_W-1:0]  virt_s1;
	logic [DATA_W-1:0]  data_s1;

	walk_state_t        walk_q;
	walk_state_t        walk_next;
	logic [1:0]         n_res;
	result_t            res0;
	result_t            res1;
	result_t            head;
	logic               room_for_two;
	logic               fire_s1;
	logic               s_accept;

	assign cfg_ready = 1'b1;

	// The held transaction is processed once the queue can take both possible results.
	assign fire_s1  = valid_s1 && room_for_two;
	assign s_tready = !valid_s1 || fire_s1;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_frame_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			root_frame_q <= cfg_data;
		end
	end

	// Input register: the valid flag is control, the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_s1  <= req_type_t'(s_tuser);
			virt_s1 <= s_tdata[VIRT_W-1:0];
			data_s1 <= s_tdata[VIRT_W+DATA_W-1:VIRT_W];
		end
	end

	// Walk context is updated only when the held transaction is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (fire_s1) begin
			walk_q <= walk_next;
		end
	end

	flptw_step #(
		.PHYS_ADDR_BITS(PHYS_ADDR_BITS)
	) u_step (
		.req        (req_s1),
		.virt_addr  (virt_s1),
		.read_data  (data_s1),
		.root_frame (root_frame_q),
		.cur        (walk_q),
		.nxt        (walk_next),
		.n_res      (n_res),
		.res0       (res0),
		.res1       (res1)
	);

	flptw_ofifo u_ofifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.n_push       (fire_s1 ? n_res : 2'd0),
		.push0        (res0),
		.push1        (res1),
		.room_for_two (room_for_two),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_res      (head)
	);

	assign m_tdata = {6'b0, head.status, head.phys_addr, head.mem_addr};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

`default_nettype wire
